// ===== rtl/core/stb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package stb_pkg;

  localparam int SIZE_W  = 11;
  localparam int TC_W    = 11;
  localparam int STAT_W  = 3;
  localparam int NUM_W   = 10;
  localparam int START_W = 14;
  localparam int CNT_W   = 11;
  localparam int TOTAL_W = 14;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_BUILD = 3'd2;
  localparam logic [2:0] CMD_RANGE = 3'd3;
  localparam logic [2:0] CMD_ENTRY = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_BAD_ADDR = 3'd3;
  localparam logic [2:0] ST_CULLED   = 3'd4;

  localparam logic [2:0] REG_WIDTH_ADDR  = 3'd0;
  localparam logic [2:0] REG_HEIGHT_ADDR = 3'd4;

  localparam int RECIP_SH = 20;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [23:0] mid_x;
    logic signed [23:0] mid_y;
    logic signed [23:0] axis0_x;
    logic signed [23:0] axis0_y;
    logic signed [23:0] axis1_x;
    logic signed [23:0] axis1_y;
    logic [12:0]        address;
  } stb_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [NUM_W-1:0]   splat_number;
    logic [START_W-1:0] range_start;
    logic [CNT_W-1:0]   range_count;
    logic [NUM_W-1:0]   list_entry;
    logic [TOTAL_W-1:0] total_entries;
  } stb_out_t;

  typedef struct packed {
    logic            valid;
    logic [TC_W-1:0] tx0;
    logic [TC_W-1:0] tx1;
    logic [TC_W-1:0] ty0;
    logic [TC_W-1:0] ty1;
  } stb_box_t;

  typedef struct packed {
    logic latch;
    logic add1;
    logic add2;
    logic add3;
    logic bset;
    logic tbegin;
    logic scan;
    logic tend;
    logic rd;
    logic emit;
  } stb_cmd_t;

  typedef struct packed {
    logic full;
    logic grid_zero;
    logic no_splats;
    logic s_last;
    logic t_last;
  } stb_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/stb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/stb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [2:0]        command,
  input  wire stb_pkg::stb_stat_t stat,
  output logic                   busy,
  output stb_pkg::stb_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_ADD1   = 4'd2;
  localparam logic [3:0] S_ADD2   = 4'd3;
  localparam logic [3:0] S_ADD3   = 4'd4;
  localparam logic [3:0] S_BSET   = 4'd5;
  localparam logic [3:0] S_BTILE  = 4'd6;
  localparam logic [3:0] S_BSCAN  = 4'd7;
  localparam logic [3:0] S_BDRAIN = 4'd8;
  localparam logic [3:0] S_BEND   = 4'd9;
  localparam logic [3:0] S_RD     = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0] state, state_next;
  logic [2:0] op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= stb_pkg::CMD_CLEAR;
    end else begin
      state <= state_next;
      if (state == S_IDLE && start) begin
        op <= command;
      end
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        unique case (op) inside
          stb_pkg::CMD_ADD:   state_next = stat.full ? S_FIN : S_ADD1;
          stb_pkg::CMD_BUILD: state_next = S_BSET;
          stb_pkg::CMD_RANGE,
          stb_pkg::CMD_ENTRY: state_next = S_RD;
          default:            state_next = S_FIN;
        endcase
      end
      S_ADD1: begin
        cmd.add1   = 1'b1;
        state_next = S_ADD2;
      end
      S_ADD2: begin
        cmd.add2   = 1'b1;
        state_next = S_ADD3;
      end
      S_ADD3: begin
        cmd.add3   = 1'b1;
        state_next = S_FIN;
      end
      S_BSET: begin
        cmd.bset   = 1'b1;
        state_next = stat.grid_zero ? S_FIN : S_BTILE;
      end
      S_BTILE: begin
        cmd.tbegin = 1'b1;
        state_next = stat.no_splats ? S_BEND : S_BSCAN;
      end
      S_BSCAN: begin
        cmd.scan = 1'b1;
        if (stat.s_last) begin
          state_next = S_BDRAIN;
        end
      end
      S_BDRAIN: state_next = S_BEND;
      S_BEND: begin
        cmd.tend   = 1'b1;
        state_next = stat.t_last ? S_FIN : S_BTILE;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/stb_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stb_dpath #(
  parameter int TILE_SIZE     = 16,
  parameter int MAX_SPLATS    = 1024,
  parameter int MAX_TILES     = 4096,
  parameter int LIST_CAPACITY = 8192
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire stb_pkg::stb_cmd_t           cmd,
  input  wire stb_pkg::stb_in_t            item,
  input  wire logic [stb_pkg::SIZE_W-1:0]  image_width,
  input  wire logic [stb_pkg::SIZE_W-1:0]  image_height,
  output stb_pkg::stb_stat_t               stat,
  output logic                             done,
  output stb_pkg::stb_out_t                result
);

  localparam int SIDX_W = MAX_SPLATS > 1 ? $clog2(MAX_SPLATS) : 1;
  localparam int SCNT_W = $clog2(MAX_SPLATS + 1);
  localparam int TIDX_W = MAX_TILES > 1 ? $clog2(MAX_TILES) : 1;
  localparam int TCNT_W = $clog2(MAX_TILES + 1);
  localparam int LIDX_W = LIST_CAPACITY > 1 ? $clog2(LIST_CAPACITY) : 1;
  localparam int LEN_W  = $clog2(LIST_CAPACITY + 1);
  localparam int RECIP  = (2 ** stb_pkg::RECIP_SH + TILE_SIZE - 1) / TILE_SIZE;
  localparam int GRID_W = 2 * stb_pkg::TC_W;
  localparam int BOX_W  = $bits(stb_pkg::stb_box_t);
  localparam int RNG_W  = LEN_W + SCNT_W;

  // Divide by the tile size through a reciprocal multiply.
  function automatic logic [stb_pkg::TC_W-1:0] tdiv(input logic [11:0] x);
    logic [32:0] p;
    p = 33'(x) * 33'(RECIP);
    return stb_pkg::TC_W'(p >> stb_pkg::RECIP_SH);
  endfunction

  stb_pkg::stb_in_t lat;

  logic signed [36:0] pcx, pcy;
  logic [37:0]        prx, pry;
  logic [10:0]        lo_x, hi_x, lo_y, hi_y;
  logic               box_ok;
  stb_pkg::stb_box_t  box_new;

  logic [SCNT_W-1:0]  count;
  logic [LEN_W-1:0]   len;
  logic               ovf;
  logic [TCNT_W-1:0]  t;
  logic [10:0]        tx, ty;
  logic [SCNT_W-1:0]  s, s_d;
  logic               proc_v;
  logic [LEN_W-1:0]   t_start;
  logic [SCNT_W-1:0]  t_cnt;
  logic [10:0]        across, down;
  logic [TCNT_W-1:0]  grid_n;
  logic               addr_ok;
  stb_pkg::stb_out_t  result_next;

  // Grid size follows the registers.
  logic [GRID_W-1:0] grid_raw;
  assign grid_raw = GRID_W'(across) * GRID_W'(down);

  always_ff @(posedge clk) begin
    across <= tdiv(12'(image_width) + 12'(TILE_SIZE - 1));
    down   <= tdiv(12'(image_height) + 12'(TILE_SIZE - 1));
    grid_n <= (grid_raw > GRID_W'(MAX_TILES)) ? TCNT_W'(MAX_TILES) : TCNT_W'(grid_raw);
  end

  // Box arithmetic
  logic signed [24:0] cx_off, cy_off;
  logic [23:0]        m0x, m1x, m0y, m1y;
  logic [24:0]        sum_x, sum_y;
  logic [26:0]        r3_x, r3_y;
  logic signed [11:0] w_s, h_s;

  assign cx_off = 25'(lat.mid_x) + 25'sd65536;
  assign cy_off = 25'sd65536 - 25'(lat.mid_y);
  assign m0x = lat.axis0_x[23] ? 24'(-lat.axis0_x) : 24'(lat.axis0_x);
  assign m1x = lat.axis1_x[23] ? 24'(-lat.axis1_x) : 24'(lat.axis1_x);
  assign m0y = lat.axis0_y[23] ? 24'(-lat.axis0_y) : 24'(lat.axis0_y);
  assign m1y = lat.axis1_y[23] ? 24'(-lat.axis1_y) : 24'(lat.axis1_y);
  assign sum_x = 25'(m0x) + 25'(m1x);
  assign sum_y = 25'(m0y) + 25'(m1y);
  assign r3_x = 27'(sum_x) + {1'b0, sum_x, 1'b0};
  assign r3_y = 27'(sum_y) + {1'b0, sum_y, 1'b0};
  assign w_s = $signed({1'b0, image_width});
  assign h_s = $signed({1'b0, image_height});

  logic signed [39:0] lo_rx, hi_rx, lo_ry, hi_ry;
  logic signed [39:0] lo_fx, hi_fx, lo_fy, hi_fy;
  logic signed [39:0] lo_cx, hi_cx, lo_cy, hi_cy;
  logic signed [39:0] lim_x, lim_y;

  assign lo_rx = 40'(pcx) - $signed({2'b00, prx});
  assign hi_rx = 40'(pcx) + $signed({2'b00, prx}) + 40'sd131071;
  assign lo_ry = 40'(pcy) - $signed({2'b00, pry});
  assign hi_ry = 40'(pcy) + $signed({2'b00, pry}) + 40'sd131071;
  assign lo_fx = lo_rx >>> 17;
  assign hi_fx = hi_rx >>> 17;
  assign lo_fy = lo_ry >>> 17;
  assign hi_fy = hi_ry >>> 17;
  assign lim_x = $signed({29'd0, image_width}) - 40'sd1;
  assign lim_y = $signed({29'd0, image_height}) - 40'sd1;
  assign lo_cx = (lo_fx < 40'sd0) ? 40'sd0 : lo_fx;
  assign hi_cx = (hi_fx > lim_x) ? lim_x : hi_fx;
  assign lo_cy = (lo_fy < 40'sd0) ? 40'sd0 : lo_fy;
  assign hi_cy = (hi_fy > lim_y) ? lim_y : hi_fy;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat <= item;
    end
    if (cmd.add1) begin
      pcx <= 37'(cx_off) * 37'(w_s);
      pcy <= 37'(cy_off) * 37'(h_s);
      prx <= 38'(r3_x) * 38'(image_width);
      pry <= 38'(r3_y) * 38'(image_height);
    end
    if (cmd.add2) begin
      lo_x   <= lo_cx[10:0];
      hi_x   <= hi_cx[10:0];
      lo_y   <= lo_cy[10:0];
      hi_y   <= hi_cy[10:0];
      box_ok <= (lo_cx <= hi_cx) && (lo_cy <= hi_cy);
    end
    if (cmd.add3) begin
      if (box_ok) begin
        box_new.valid <= 1'b1;
        box_new.tx0   <= tdiv({1'b0, lo_x});
        box_new.tx1   <= tdiv({1'b0, hi_x});
        box_new.ty0   <= tdiv({1'b0, lo_y});
        box_new.ty1   <= tdiv({1'b0, hi_y});
      end else begin
        box_new <= '0;
      end
    end
  end

  // Memories
  logic              full;
  logic [BOX_W-1:0]  box_rdata;
  stb_pkg::stb_box_t box_rd;
  logic              covers;
  logic              list_we;
  logic [SIDX_W-1:0] list_rdata;
  logic [RNG_W-1:0]  rng_rdata;

  assign full   = (count >= SCNT_W'(MAX_SPLATS));
  assign box_rd = box_rdata;
  assign covers = box_rd.valid && tx >= box_rd.tx0 && tx <= box_rd.tx1 &&
                  ty >= box_rd.ty0 && ty <= box_rd.ty1;
  assign list_we = proc_v && covers && (len < LEN_W'(LIST_CAPACITY));

  stb_ram #(.WIDTH(BOX_W), .DEPTH(MAX_SPLATS)) u_box_ram (
    .clk   (clk),
    .we    (cmd.emit && lat.command == stb_pkg::CMD_ADD && !full),
    .waddr (count[SIDX_W-1:0]),
    .wdata (box_new),
    .raddr (s[SIDX_W-1:0]),
    .rdata (box_rdata)
  );

  stb_ram #(.WIDTH(SIDX_W), .DEPTH(LIST_CAPACITY)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (len[LIDX_W-1:0]),
    .wdata (s_d[SIDX_W-1:0]),
    .raddr (LIDX_W'(lat.address)),
    .rdata (list_rdata)
  );

  stb_ram #(.WIDTH(RNG_W), .DEPTH(MAX_TILES)) u_range_ram (
    .clk   (clk),
    .we    (cmd.tend),
    .waddr (t[TIDX_W-1:0]),
    .wdata ({t_start, t_cnt}),
    .raddr (TIDX_W'(lat.address)),
    .rdata (rng_rdata)
  );

  // Build walk
  always_ff @(posedge clk) begin
    s_d <= s;
    if (cmd.bset) begin
      t  <= '0;
      tx <= '0;
      ty <= '0;
    end
    if (cmd.tbegin) begin
      t_start <= len;
      t_cnt   <= '0;
      s       <= '0;
    end else if (cmd.scan) begin
      s <= s + 1'b1;
    end
    if (list_we) begin
      t_cnt <= t_cnt + 1'b1;
    end
    if (cmd.tend) begin
      t <= t + 1'b1;
      if (tx == across - 11'd1) begin
        tx <= '0;
        ty <= ty + 11'd1;
      end else begin
        tx <= tx + 11'd1;
      end
    end
    if (cmd.rd) begin
      if (lat.command == stb_pkg::CMD_RANGE) begin
        addr_ok <= 32'(lat.address) < 32'(grid_n);
      end else begin
        addr_ok <= 32'(lat.address) < 32'(len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      len    <= '0;
      ovf    <= 1'b0;
      proc_v <= 1'b0;
      done   <= 1'b0;
    end else begin
      proc_v <= cmd.scan;
      done   <= cmd.emit;
      if (cmd.bset) begin
        len <= '0;
        ovf <= 1'b0;
      end
      if (list_we) begin
        len <= len + 1'b1;
      end else if (proc_v && covers) begin
        ovf <= 1'b1;
      end
      if (cmd.emit) begin
        case (lat.command)
          stb_pkg::CMD_CLEAR: begin
            count <= '0;
            len   <= '0;
          end
          stb_pkg::CMD_ADD: begin
            if (!full) begin
              count <= count + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    result_next               = '0;
    result_next.total_entries = stb_pkg::TOTAL_W'(len);
    case (lat.command)
      stb_pkg::CMD_CLEAR: result_next.total_entries = '0;
      stb_pkg::CMD_ADD: begin
        if (full) begin
          result_next.status = stb_pkg::ST_FULL;
        end else begin
          result_next.splat_number = stb_pkg::NUM_W'(count);
          result_next.status = box_new.valid ? stb_pkg::ST_OK : stb_pkg::ST_CULLED;
        end
      end
      stb_pkg::CMD_BUILD: result_next.status = ovf ? stb_pkg::ST_OVERFLOW : stb_pkg::ST_OK;
      stb_pkg::CMD_RANGE: begin
        if (addr_ok) begin
          result_next.range_start = stb_pkg::START_W'(rng_rdata[RNG_W-1:SCNT_W]);
          result_next.range_count = stb_pkg::CNT_W'(rng_rdata[SCNT_W-1:0]);
        end else begin
          result_next.status = stb_pkg::ST_BAD_ADDR;
        end
      end
      stb_pkg::CMD_ENTRY: begin
        if (addr_ok) begin
          result_next.list_entry = stb_pkg::NUM_W'(list_rdata);
        end else begin
          result_next.status = stb_pkg::ST_BAD_ADDR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result <= result_next;
    end
  end

  assign stat.full      = full;
  assign stat.grid_zero = (grid_n == '0);
  assign stat.no_splats = (count == '0);
  assign stat.s_last    = (s == count - 1'b1);
  assign stat.t_last    = (t == grid_n - 1'b1);

endmodule
`default_nettype wire

// ===== rtl/core/splat_tile_binner.sv =====
// Clear, unknown commands and an add to a full store go from decode to the
// result; add runs the box arithmetic, read range and read entry a read; build
// walks every tile, skipping the scan with no splats. One command at a time;
// busy stays high until the result strobe is issued. The build time is set by
// the walk of every splat box per tile; done is high for one cycle, no stall.
// Synchronous reset: image size 1024x1024, splat count and list length zero.
`timescale 1ns / 1ps
`default_nettype none
module splat_tile_binner #(
  parameter int TILE_SIZE     = 16,
  parameter int MAX_SPLATS    = 1024,
  parameter int MAX_TILES     = 4096,
  parameter int LIST_CAPACITY = 8192
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire stb_pkg::stb_in_t  item,
  output logic                   done,
  output stb_pkg::stb_out_t      result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [stb_pkg::SIZE_W-1:0] image_width, image_height;
  stb_pkg::stb_cmd_t  cmd;
  stb_pkg::stb_stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1024;
      image_height <= 11'd1024;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        stb_pkg::REG_WIDTH_ADDR:  image_width  <= pwdata[stb_pkg::SIZE_W-1:0];
        stb_pkg::REG_HEIGHT_ADDR: image_height <= pwdata[stb_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      stb_pkg::REG_WIDTH_ADDR:  prdata = 32'(image_width);
      stb_pkg::REG_HEIGHT_ADDR: prdata = 32'(image_height);
      default:                  prdata = '0;
    endcase
  end

  stb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (item.command),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  stb_dpath #(
    .TILE_SIZE     (TILE_SIZE),
    .MAX_SPLATS    (MAX_SPLATS),
    .MAX_TILES     (MAX_TILES),
    .LIST_CAPACITY (LIST_CAPACITY)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .image_width  (image_width),
    .image_height (image_height),
    .stat         (stat),
    .done         (done),
    .result       (result)
  );

endmodule
`default_nettype wire
